[src/ara_pkg.sv]
// ----------------------------------------------------------------------------
// ara_pkg
// Shared types and codes for the address range allocator.
// ----------------------------------------------------------------------------
package ara_pkg;

  localparam int unsigned AddrW = 64;
  localparam int unsigned CmdW = 2;
  localparam int unsigned StatusW = 3;
  localparam int unsigned CfgIdxW = 1;

  localparam logic [CmdW-1:0] CMD_INIT  = 2'd0;
  localparam logic [CmdW-1:0] CMD_ALLOC = 2'd1;
  localparam logic [CmdW-1:0] CMD_FREE  = 2'd2;
  localparam logic [CmdW-1:0] CMD_CLEAR = 2'd3;

  localparam logic [StatusW-1:0] ST_OK      = 3'd0;
  localparam logic [StatusW-1:0] ST_INVALID = 3'd1;
  localparam logic [StatusW-1:0] ST_NOSPACE = 3'd2;
  localparam logic [StatusW-1:0] ST_OVERLAP = 3'd3;
  localparam logic [StatusW-1:0] ST_FULL    = 3'd4;

  localparam logic [CfgIdxW-1:0] CFG_BASE   = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_LENGTH = 1'b1;

  typedef logic [AddrW-1:0] addr_t;

  typedef struct packed {
    logic [CmdW-1:0] command;
    addr_t           address;
    addr_t           length;
  } req_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    addr_t              granted_address;
    logic               is_empty;
  } rsp_t;

endpackage

[src/ara_req_if.sv]
// ----------------------------------------------------------------------------
// ara_req_if
// Request channel: valid/ready with one request payload.
// ----------------------------------------------------------------------------
interface ara_req_if;
  logic          valid;
  logic          ready;
  ara_pkg::req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[src/ara_rsp_if.sv]
// ----------------------------------------------------------------------------
// ara_rsp_if
// Result channel: valid/ready with one result payload.
// ----------------------------------------------------------------------------
interface ara_rsp_if;
  logic          valid;
  logic          ready;
  ara_pkg::rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[src/address_range_allocator_top.sv]
// ----------------------------------------------------------------------------
// address_range_allocator_top
// Best-fit free extent allocator with coalescing over a sorted extent memory.
// ----------------------------------------------------------------------------
// One request at a time. The free extents sit sorted by start in one
// synchronous memory (start and length per entry). An allocate or free request
// scans the used entries one read per cycle, then, where an entry must be
// inserted or removed, shifts the tail one entry at a time (read, then write),
// then writes the changed entries back, all through the single memory port.
// in.ready is high only while idle, but a finished result waits in the output
// register and the next request may be taken meanwhile. No clearing pass:
// entries beyond the count are never read.
module address_range_allocator_top #(
  parameter int unsigned MAX_EXTENTS = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [ara_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [ara_pkg::AddrW-1:0]   cfg_data,
  ara_req_if.sink                     in_req,
  ara_rsp_if.source                   out_rsp
);

  localparam int unsigned IdxW = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
  localparam int unsigned CntW = $clog2(MAX_EXTENTS + 1);
  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_EXTENTS);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SCAN  = 6'b000010,
    S_DEC   = 6'b000100,
    S_SHIFT = 6'b001000,
    S_WB    = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  // extent memory
  logic [2*ara_pkg::AddrW-1:0] mem [MAX_EXTENTS];
  logic                        rd_en;
  logic [IdxW-1:0]             rd_addr;
  logic [2*ara_pkg::AddrW-1:0] rd_data_r;
  logic                        we;
  logic [IdxW-1:0]             wa;
  logic [2*ara_pkg::AddrW-1:0] wd;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  ara_pkg::addr_t rs, rl;
  assign rs = rd_data_r[2*ara_pkg::AddrW-1:ara_pkg::AddrW];
  assign rl = rd_data_r[ara_pkg::AddrW-1:0];

  ara_pkg::addr_t base_r, len_cfg_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= '0;
      len_cfg_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        ara_pkg::CFG_BASE:   base_r <= cfg_data;
        ara_pkg::CFG_LENGTH: len_cfg_r <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [CntW-1:0] cnt_r, cnt_nxt;
  ara_pkg::req_t   req_r;
  // scan pointers: k = next read, j = index of entry in rd_data
  logic [CntW-1:0] rk_r, rk_nxt, jk_r, jk_nxt;
  logic            pend_r, pend_nxt;   // rd_data holds entry jk_r
  // best fit tracking
  logic            bf_found_r, bf_found_nxt;
  logic [CntW-1:0] bf_idx_r, bf_idx_nxt;
  ara_pkg::addr_t  bf_s_r, bf_s_nxt, bf_l_r, bf_l_nxt;
  // position search: pos = first start above a, with prev/next entries
  logic [CntW-1:0] pos_r, pos_nxt;
  logic            pos_done_r, pos_done_nxt;
  ara_pkg::addr_t  pv_s_r, pv_s_nxt, pv_l_r, pv_l_nxt;
  ara_pkg::addr_t  nx_s_r, nx_s_nxt, nx_l_r, nx_l_nxt;
  // edit plan
  logic [1:0]      shop_r, shop_nxt;   // 0 none, 1 insert, 2 delete
  logic [CntW-1:0] shat_r, shat_nxt;   // insert/delete index
  logic [CntW-1:0] shk_r, shk_nxt;
  logic            w0_r, w0_nxt, w1_r, w1_nxt;
  logic [CntW-1:0] w0i_r, w0i_nxt, w1i_r, w1i_nxt;
  ara_pkg::addr_t  w0s_r, w0s_nxt, w0l_r, w0l_nxt, w1s_r, w1s_nxt, w1l_r, w1l_nxt;
  logic [ara_pkg::StatusW-1:0] st_r, st_nxt;
  ara_pkg::addr_t  gr_r, gr_nxt;
  logic            shw_r, shw_nxt;     // shift read outstanding
  ara_pkg::rsp_t   out_r, out_nxt;
  logic            ov_r, ov_nxt;

  localparam logic [1:0] OP_NONE = 2'd0;
  localparam logic [1:0] OP_INS  = 2'd1;
  localparam logic [1:0] OP_DEL  = 2'd2;

  logic acc_in;
  assign in_req.ready = (state_r == S_IDLE);
  assign acc_in = in_req.valid && in_req.ready;
  assign out_rsp.valid = ov_r;
  assign out_rsp.data = out_r;

  ara_pkg::addr_t a, ln, end_a, pv_end, avail, right_l;
  logic [ara_pkg::AddrW:0] init_sum, free_sum;
  assign a = req_r.address;
  assign ln = req_r.length;
  assign end_a = a + ln;
  assign pv_end = pv_s_r + pv_l_r;
  assign avail = pv_end - a;
  assign right_l = avail - ln;
  assign init_sum = {1'b0, base_r} + {1'b0, len_cfg_r};
  assign free_sum = {1'b0, a} + {1'b0, ln};

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    rk_nxt = rk_r; jk_nxt = jk_r; pend_nxt = 1'b0;
    bf_found_nxt = bf_found_r; bf_idx_nxt = bf_idx_r;
    bf_s_nxt = bf_s_r; bf_l_nxt = bf_l_r;
    pos_nxt = pos_r; pos_done_nxt = pos_done_r;
    pv_s_nxt = pv_s_r; pv_l_nxt = pv_l_r; nx_s_nxt = nx_s_r; nx_l_nxt = nx_l_r;
    shop_nxt = shop_r; shat_nxt = shat_r; shk_nxt = shk_r; shw_nxt = 1'b0;
    w0_nxt = w0_r; w1_nxt = w1_r; w0i_nxt = w0i_r; w1i_nxt = w1i_r;
    w0s_nxt = w0s_r; w0l_nxt = w0l_r; w1s_nxt = w1s_r; w1l_nxt = w1l_r;
    st_nxt = st_r; gr_nxt = gr_r;
    out_nxt = out_r; ov_nxt = ov_r;
    rd_en = 1'b0; rd_addr = '0;
    we = 1'b0; wa = '0; wd = '0;
    if (ov_r && out_rsp.ready) begin
      ov_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (acc_in) begin
          rk_nxt = '0; bf_found_nxt = 1'b0; pos_nxt = '0; pos_done_nxt = 1'b0;
          shop_nxt = OP_NONE; w0_nxt = 1'b0; w1_nxt = 1'b0;
          st_nxt = ara_pkg::ST_OK; gr_nxt = '0;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        // consume entry read last cycle
        if (pend_r) begin
          if (rl >= ln && (!bf_found_r || rl < bf_l_r)) begin
            bf_found_nxt = 1'b1; bf_idx_nxt = jk_r; bf_s_nxt = rs; bf_l_nxt = rl;
          end
          if (!pos_done_r) begin
            if (rs <= a) begin
              pos_nxt = jk_r + 1'b1; pv_s_nxt = rs; pv_l_nxt = rl;
            end else begin
              pos_done_nxt = 1'b1; nx_s_nxt = rs; nx_l_nxt = rl;
            end
          end
        end
        if (rk_r < cnt_r && (req_r.command == ara_pkg::CMD_ALLOC ||
                             req_r.command == ara_pkg::CMD_FREE)) begin
          rd_en = 1'b1; rd_addr = rk_r[IdxW-1:0];
          jk_nxt = rk_r; rk_nxt = rk_r + 1'b1; pend_nxt = 1'b1;
        end else if (!pend_r) begin
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        state_nxt = S_WB;
        case (req_r.command)
          ara_pkg::CMD_INIT: begin
            if (len_cfg_r == '0 || init_sum[ara_pkg::AddrW]) begin
              st_nxt = ara_pkg::ST_INVALID;
            end else begin
              cnt_nxt = CntW'(1);
              w0_nxt = 1'b1; w0i_nxt = '0; w0s_nxt = base_r; w0l_nxt = len_cfg_r;
            end
          end
          ara_pkg::CMD_CLEAR: cnt_nxt = '0;
          ara_pkg::CMD_ALLOC: begin
            if (ln == '0) begin
              st_nxt = ara_pkg::ST_INVALID;
            end else if (a == '0) begin
              if (!bf_found_r) begin
                st_nxt = ara_pkg::ST_NOSPACE;
              end else if (bf_l_r == ln) begin
                gr_nxt = bf_s_r; shop_nxt = OP_DEL; shat_nxt = bf_idx_r;
              end else begin
                gr_nxt = bf_s_r + (bf_l_r - ln);
                w0_nxt = 1'b1; w0i_nxt = bf_idx_r; w0s_nxt = bf_s_r;
                w0l_nxt = bf_l_r - ln;
              end
            end else if (pos_r == '0 || a > pv_end) begin
              st_nxt = ara_pkg::ST_NOSPACE;
            end else if (a == pv_end) begin
              st_nxt = ara_pkg::ST_INVALID;
            end else if (a == pv_s_r) begin
              if (pv_l_r < ln) begin
                st_nxt = ara_pkg::ST_NOSPACE;
              end else if (pv_l_r == ln) begin
                gr_nxt = a; shop_nxt = OP_DEL; shat_nxt = pos_r - 1'b1;
              end else begin
                gr_nxt = a;
                w0_nxt = 1'b1; w0i_nxt = pos_r - 1'b1; w0s_nxt = a + ln;
                w0l_nxt = pv_l_r - ln;
              end
            end else if (ln > avail) begin
              st_nxt = ara_pkg::ST_NOSPACE;
            end else if (right_l != '0 && cnt_r >= MaxCnt) begin
              st_nxt = ara_pkg::ST_FULL;
            end else begin
              gr_nxt = a;
              w0_nxt = 1'b1; w0i_nxt = pos_r - 1'b1; w0s_nxt = pv_s_r;
              w0l_nxt = a - pv_s_r;
              if (right_l != '0) begin
                shop_nxt = OP_INS; shat_nxt = pos_r;
                w1_nxt = 1'b1; w1i_nxt = pos_r; w1s_nxt = end_a; w1l_nxt = right_l;
              end
            end
          end
          default: begin // free
            if (ln == '0 || free_sum[ara_pkg::AddrW]) begin
              st_nxt = ara_pkg::ST_INVALID;
            end else if (pos_r != '0 && (pv_end > a || pv_s_r == a)) begin
              st_nxt = ara_pkg::ST_OVERLAP;
            end else if (pos_r < cnt_r && nx_s_r < end_a) begin
              st_nxt = ara_pkg::ST_OVERLAP;
            end else if (pos_r != '0 && pv_end == a) begin
              w0_nxt = 1'b1; w0i_nxt = pos_r - 1'b1; w0s_nxt = pv_s_r;
              if (pos_r < cnt_r && nx_s_r == end_a) begin
                w0l_nxt = pv_l_r + ln + nx_l_r; shop_nxt = OP_DEL; shat_nxt = pos_r;
              end else begin
                w0l_nxt = pv_l_r + ln;
              end
            end else if (pos_r < cnt_r && nx_s_r == end_a) begin
              w0_nxt = 1'b1; w0i_nxt = pos_r; w0s_nxt = a; w0l_nxt = nx_l_r + ln;
            end else if (cnt_r >= MaxCnt) begin
              st_nxt = ara_pkg::ST_FULL;
            end else begin
              shop_nxt = OP_INS; shat_nxt = pos_r;
              w1_nxt = 1'b1; w1i_nxt = pos_r; w1s_nxt = a; w1l_nxt = ln;
            end
          end
        endcase
        if (st_nxt == ara_pkg::ST_OK) begin
          if (shop_nxt == OP_INS) begin
            shk_nxt = cnt_r; state_nxt = S_SHIFT;
          end else if (shop_nxt == OP_DEL) begin
            shk_nxt = shat_nxt; state_nxt = S_SHIFT;
          end
        end else begin
          gr_nxt = '0;
        end
      end
      S_SHIFT: begin
        // one read, then one write per moved entry
        if (shw_r) begin
          we = 1'b1; wd = rd_data_r;
          if (shop_r == OP_INS) begin
            // insert moves entry shk up to shk+1
            wa = IdxW'(shk_r + 1'b1);
          end else begin
            wa = IdxW'(shk_r - 1'b1);
          end
        end else if (shop_r == OP_INS && shk_r > shat_r) begin
          rd_en = 1'b1; rd_addr = IdxW'(shk_r - 1'b1);
          shw_nxt = 1'b1; shk_nxt = shk_r - 1'b1;
        end else if (shop_r == OP_DEL && shk_r + 1'b1 < cnt_r) begin
          rd_en = 1'b1; rd_addr = IdxW'(shk_r + 1'b1);
          shw_nxt = 1'b1; shk_nxt = shk_r + 1'b1;
        end else begin
          cnt_nxt = (shop_r == OP_INS) ? cnt_r + 1'b1 : cnt_r - 1'b1;
          state_nxt = S_WB;
        end
      end
      S_WB: begin
        if (w0_r) begin
          we = 1'b1; wa = w0i_r[IdxW-1:0]; wd = {w0s_r, w0l_r}; w0_nxt = 1'b0;
        end else if (w1_r) begin
          we = 1'b1; wa = w1i_r[IdxW-1:0]; wd = {w1s_r, w1l_r}; w1_nxt = 1'b0;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!ov_r || out_rsp.ready) begin
          ov_nxt = 1'b1;
          out_nxt.status = st_r;
          out_nxt.granted_address = gr_r;
          out_nxt.is_empty = (cnt_r == '0);
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r <= '0;
      ov_r <= 1'b0;
      pend_r <= 1'b0;
      shw_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      ov_r <= ov_nxt;
      pend_r <= pend_nxt;
      shw_r <= shw_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc_in) begin
      req_r <= in_req.data;
    end
    rk_r <= rk_nxt; jk_r <= jk_nxt;
    bf_found_r <= bf_found_nxt; bf_idx_r <= bf_idx_nxt;
    bf_s_r <= bf_s_nxt; bf_l_r <= bf_l_nxt;
    pos_r <= pos_nxt; pos_done_r <= pos_done_nxt;
    pv_s_r <= pv_s_nxt; pv_l_r <= pv_l_nxt; nx_s_r <= nx_s_nxt; nx_l_r <= nx_l_nxt;
    shop_r <= shop_nxt; shat_r <= shat_nxt; shk_r <= shk_nxt;
    w0_r <= w0_nxt; w1_r <= w1_nxt; w0i_r <= w0i_nxt; w1i_r <= w1i_nxt;
    w0s_r <= w0s_nxt; w0l_r <= w0l_nxt; w1s_r <= w1s_nxt; w1l_r <= w1l_nxt;
    st_r <= st_nxt; gr_r <= gr_nxt;
    out_r <= out_nxt;
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= MaxCnt) else $error("extent count over capacity");
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_req.ready |-> state_r == S_IDLE) else $error("ready outside idle");
  a_no_write_scan: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCAN |-> !we) else $error("memory write during scan");
  a_fail_no_grant: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && out_r.status != ara_pkg::ST_OK) |-> out_r.granted_address == '0)
    else $error("grant on failed request");

endmodule
